// ===== design/rppr_pkg.sv =====
// Package for the rotary position pair rotator: widths, constants, shared types
// and the fixed-point helper functions. No dependencies.
package rppr_pkg;

  localparam int DEF_MAX_POSITIONS  = 4096;
  localparam int DEF_MAX_HALF_WIDTH = 64;
  localparam int DEF_CORDIC_STAGES  = 24;

  localparam int POS_W   = 12;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 32;
  localparam int HW_W    = 7;
  localparam int AP_W    = 13;
  localparam int RATIO_W = 32;
  localparam int FREQ_W  = 33;                // Q1.32
  localparam int ANGLE_W = POS_W + FREQ_W;    // Q13.32
  localparam int CW      = 34;                // CORDIC x, y and z width

  // register indexes of the configuration port
  localparam logic [1:0] CFG_HALF_WIDTH       = 2'd0;
  localparam logic [1:0] CFG_FREQUENCY_RATIO  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_POSITIONS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;

  localparam logic [HW_W-1:0]    RST_HALF_WIDTH       = 7'd32;
  localparam logic [RATIO_W-1:0] RST_FREQUENCY_RATIO  = 32'd3220753026;
  localparam logic [AP_W-1:0]    RST_ACTIVE_POSITIONS = 13'd4096;

  localparam logic [FREQ_W-1:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [ANGLE_W-1:0] TWO_PI_Q32 = 45'd26986075409;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // powers ratio^(2^k) for each bit of the pair index
  typedef logic [IDX_W-1:0][RATIO_W-1:0] power_set_t;

  typedef struct packed {
    logic [HW_W-1:0] half_width;
    logic [AP_W-1:0] active_positions;
    power_set_t      powers;
    logic            busy;
  } cfg_state_t;

  // fields that ride along the pipeline beside the arithmetic
  typedef struct packed {
    logic                    opcode;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } side_t;

  // rounded Q0.32 product
  function automatic logic [31:0] qmul32(logic [31:0] x, logic [31:0] y);
    logic [63:0] prod;
    prod = 64'(x) * 64'(y) + 64'h8000_0000;
    return prod[63:32];
  endfunction

  // Q1.32 frequency times a Q0.32 power; 1.0 times p is p exactly
  function automatic logic [FREQ_W-1:0] fmul(logic [FREQ_W-1:0] f, logic [31:0] p);
    logic [FREQ_W-1:0] res;
    if (f[32]) begin
      res = {1'b0, p};
    end else begin
      res = {1'b0, qmul32(f[31:0], p)};
    end
    return res;
  endfunction

  // truncated Q.30 arctangent of 2^-i
  function automatic logic [31:0] atan_entry(int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      default: begin
        if (i <= 30) v = 32'd1 << (30 - i);
        else v = 32'd0;
      end
    endcase
    return v;
  endfunction

endpackage

// ===== design/rppr_channels.sv =====
// Channel interfaces of the rotary position pair rotator: input items, results
// and configuration writes. Depends on rppr_pkg.
interface rppr_in_if import rppr_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [POS_W-1:0]        position;
  logic [IDX_W-1:0]        pair_index;
  logic signed [VAL_W-1:0] first_value;
  logic signed [VAL_W-1:0] second_value;
  modport source (output valid, opcode, position, pair_index, first_value, second_value,
                  input ready);
  modport sink (input valid, opcode, position, pair_index, first_value, second_value,
                output ready);
endinterface

interface rppr_out_if import rppr_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] first_result;
  logic signed [VAL_W-1:0] second_result;
  logic [1:0]              status;
  modport source (output valid, first_result, second_result, status, input ready);
  modport sink (input valid, first_result, second_result, status, output ready);
endinterface

interface rppr_cfg_if import rppr_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rppr_config.sv =====
// Configuration registers and the power table ratio^(2^k), refilled by a
// squaring sequencer after reset and after each ratio write. Depends on rppr_pkg.
module rppr_config import rppr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_state_t  state
);

  logic [HW_W-1:0]    half_width;
  logic [AP_W-1:0]    active_positions;
  power_set_t         powers;
  logic [31:0]        square;
  logic [2:0]         step;
  logic [31:0]        square_next;

  assign square_next = qmul32(square, square);

  // register writes and one squaring per cycle until the table is full
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width       <= RST_HALF_WIDTH;
      active_positions <= RST_ACTIVE_POSITIONS;
      powers[0]        <= RST_FREQUENCY_RATIO;
      square           <= RST_FREQUENCY_RATIO;
      step             <= 3'd1;
    end else begin
      if (step < 3'(IDX_W)) begin
        powers[step] <= square_next;
        square       <= square_next;
        step         <= step + 3'd1;
      end
      if (wr_en) begin
        case (wr_index)
          CFG_HALF_WIDTH:       half_width <= wr_data[HW_W-1:0];
          CFG_FREQUENCY_RATIO: begin
            powers[0] <= wr_data;
            square    <= wr_data;
            step      <= 3'd1;
          end
          CFG_ACTIVE_POSITIONS: active_positions <= wr_data[AP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign state.half_width       = half_width;
  assign state.active_positions = active_positions;
  assign state.powers           = powers;
  assign state.busy             = step < 3'(IDX_W);

endmodule

// ===== design/rppr_freq.sv =====
// Frequency stages: multiply in the power table entry of each set pair index
// bit, one per stage, then the position product. Depends on rppr_pkg.
module rppr_freq import rppr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [POS_W-1:0]   position,
  input  logic [IDX_W-1:0]   pair_index,
  input  side_t              in_side,
  input  power_set_t         powers,
  output logic               out_valid,
  output logic [ANGLE_W-1:0] angle,
  output side_t              out_side
);

  logic [IDX_W-1:0]  vld;
  logic [FREQ_W-1:0] f   [IDX_W];
  logic [POS_W-1:0]  pos [IDX_W];
  logic [IDX_W-1:0]  idx [IDX_W];
  side_t             sd  [IDX_W];

  for (genvar k = 0; k < IDX_W; k++) begin : g_bit
    logic              v_in;
    logic [FREQ_W-1:0] f_in;
    logic [POS_W-1:0]  p_in;
    logic [IDX_W-1:0]  i_in;
    side_t             s_in;
    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign f_in = ONE_Q32;
      assign p_in = position;
      assign i_in = pair_index;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign f_in = f[k-1];
      assign p_in = pos[k-1];
      assign i_in = idx[k-1];
      assign s_in = sd[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (adv) vld[k] <= v_in;
    end

    // multiply in this bit's power when the bit is set
    always_ff @(posedge clk) begin
      if (adv) begin
        f[k]   <= i_in[k] ? fmul(f_in, powers[k]) : f_in;
        pos[k] <= p_in;
        idx[k] <= i_in;
        sd[k]  <= s_in;
      end
    end
  end

  // angle = position * frequency, Q13.32
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[IDX_W-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle    <= ANGLE_W'(pos[IDX_W-1]) * ANGLE_W'(f[IDX_W-1]);
      out_side <= sd[IDX_W-1];
    end
  end

endmodule

// ===== design/rppr_reduce.sv =====
// Angle reduction: modulo 2*pi by ten compare-subtract steps (two per stage),
// rounding to Q.30, wrap into (-pi, pi] and fold into [-pi/2, pi/2].
// Depends on rppr_pkg.
module rppr_reduce import rppr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [ANGLE_W-1:0]    angle,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic signed [CW-1:0]  z,
  output logic                  neg,
  output side_t                 out_side
);

  localparam int NR = 5;

  logic [NR-1:0]      vld;
  logic [ANGLE_W-1:0] r  [NR];
  side_t              sd [NR];

  for (genvar s = 0; s < NR; s++) begin : g_mod
    localparam logic [ANGLE_W-1:0] KA = TWO_PI_Q32 << (9 - 2 * s);
    localparam logic [ANGLE_W-1:0] KB = TWO_PI_Q32 << (8 - 2 * s);
    logic               v_in;
    logic [ANGLE_W-1:0] r_in;
    logic [ANGLE_W-1:0] t;
    side_t              s_in;
    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = angle;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[s-1];
      assign r_in = r[s-1];
      assign s_in = sd[s-1];
    end

    // take off the two multiples of 2*pi this stage owns
    always_comb begin
      t = r_in;
      if (t >= KA) t = t - KA;
      if (t >= KB) t = t - KB;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (adv) vld[s] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r[s]  <= t;
        sd[s] <= s_in;
      end
    end
  end

  // round to Q.30 and wrap into (-pi, pi]
  logic               wrap_vld;
  logic signed [35:0] wrap_z;
  side_t              wrap_sd;
  logic [35:0]        rnd;
  logic signed [35:0] zr;

  always_comb begin
    rnd = (36'(r[NR-1]) + 36'd2) >> 2;
    zr  = $signed(rnd);
    if (zr > PI_Q30) zr = zr - TWO_PI_Q30;
  end

  always_ff @(posedge clk) begin
    if (rst) wrap_vld <= 1'b0;
    else if (adv) wrap_vld <= vld[NR-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wrap_z  <= zr;
      wrap_sd <= sd[NR-1];
    end
  end

  // fold into [-pi/2, pi/2]; a fold negates cos and sin
  logic signed [35:0] zf;
  logic               nf;

  always_comb begin
    zf = wrap_z;
    nf = 1'b0;
    if (wrap_z > HALF_PI_Q30) begin
      zf = wrap_z - PI_Q30;
      nf = 1'b1;
    end else if (wrap_z < -HALF_PI_Q30) begin
      zf = wrap_z + PI_Q30;
      nf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= wrap_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z        <= zf[CW-1:0];
      neg      <= nf;
      out_side <= wrap_sd;
    end
  end

endmodule

// ===== design/rppr_cordic.sv =====
// CORDIC rotation stages, one iteration per register stage, giving cos and sin
// in Q2.30. Depends on rppr_pkg.
module rppr_cordic import rppr_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] z_in,
  input  logic                 neg_in,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out,
  output logic                 neg_out,
  output side_t                out_side
);

  logic [CORDIC_STAGES-1:0] vld;
  logic signed [CW-1:0]     x  [CORDIC_STAGES];
  logic signed [CW-1:0]     y  [CORDIC_STAGES];
  logic signed [CW-1:0]     z  [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] ng;
  side_t                    sd [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [CW-1:0] AT = CW'(atan_entry(i));
    logic                 v_in;
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] zi;
    logic                 ni;
    side_t                s_in;
    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign xi   = CORDIC_GAIN_Q30;
      assign yi   = '0;
      assign zi   = z_in;
      assign ni   = neg_in;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign xi   = x[i-1];
      assign yi   = y[i-1];
      assign zi   = z[i-1];
      assign ni   = ng[i-1];
      assign s_in = sd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (adv) vld[i] <= v_in;
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (adv) begin
        if (zi >= 0) begin
          x[i] <= xi - (yi >>> i);
          y[i] <= yi + (xi >>> i);
          z[i] <= zi - AT;
        end else begin
          x[i] <= xi + (yi >>> i);
          y[i] <= yi - (xi >>> i);
          z[i] <= zi + AT;
        end
        ng[i] <= ni;
        sd[i] <= s_in;
      end
    end
  end

  assign out_valid = vld[CORDIC_STAGES-1];
  assign cos_out   = x[CORDIC_STAGES-1];
  assign sin_out   = y[CORDIC_STAGES-1];
  assign neg_out   = ng[CORDIC_STAGES-1];
  assign out_side  = sd[CORDIC_STAGES-1];

endmodule

// ===== design/rppr_rotate.sv =====
// Pair rotation: sign fix of cos/sin, four products, sums with rounding, then
// shift, saturation and pass-through of flagged items. Depends on rppr_pkg.
module rppr_rotate import rppr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    cos_in,
  input  logic signed [CW-1:0]    sin_in,
  input  logic                    neg,
  input  side_t                   in_side,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] first_result,
  output logic signed [VAL_W-1:0] second_result,
  output logic [1:0]              status
);

  localparam logic signed [67:0] ROUND = 68'sd1 << 29;
  localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

  logic [2:0]           vld;
  logic signed [CW-1:0] c;
  logic signed [CW-1:0] s;
  side_t                sd0, sd1, sd2;
  logic signed [65:0]   pac, pbs, pbc, pas;
  logic signed [67:0]   t1, t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
  end

  // apply the fold sign
  always_ff @(posedge clk) begin
    if (adv) begin
      c   <= neg ? -cos_in : cos_in;
      s   <= neg ? -sin_in : sin_in;
      sd0 <= in_side;
    end
  end

  // products Q16.16 x Q2.30
  always_ff @(posedge clk) begin
    if (adv) begin
      pac <= 66'(sd0.a) * 66'(c);
      pbs <= 66'(sd0.b) * 66'(s);
      pbc <= 66'(sd0.b) * 66'(c);
      pas <= 66'(sd0.a) * 66'(s);
      sd1 <= sd0;
    end
  end

  // forward or transposed rotation, with rounding bias
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sd1.opcode) begin
        t1 <= 68'(pac) + 68'(pbs) + ROUND;
        t2 <= 68'(pbc) - 68'(pas) + ROUND;
      end else begin
        t1 <= 68'(pac) - 68'(pbs) + ROUND;
        t2 <= 68'(pbc) + 68'(pas) + ROUND;
      end
      sd2 <= sd1;
    end
  end

  function automatic logic signed [VAL_W-1:0] sat(logic signed [67:0] t);
    logic signed [37:0] sh;
    logic signed [VAL_W-1:0] res;
    sh = 38'(t >>> 30);
    if (sh > SAT_MAX) res = 32'sh7FFF_FFFF;
    else if (sh < SAT_MIN) res = 32'sh8000_0000;
    else res = sh[VAL_W-1:0];
    return res;
  endfunction

  // output register; flagged items keep their input values
  always_ff @(posedge clk) begin
    if (adv) begin
      status <= sd2.status;
      if (sd2.status == ST_OK) begin
        first_result  <= sat(t1);
        second_result <= sat(t2);
      end else begin
        first_result  <= sd2.a;
        second_result <= sd2.b;
      end
    end
  end

endmodule

// ===== design/rotary_position_pair_rotator_unit.sv =====
// Top level of the rotary position pair rotator: range checks, stall control
// and the pipeline chain. Depends on rppr_pkg, the channel interfaces and the
// rppr_config, rppr_freq, rppr_reduce, rppr_cordic and rppr_rotate modules.
//
//   channel   role    carries
//   in_item   sink    opcode, position, pair_index, first_value, second_value
//   out_item  source  first_result, second_result, status
//   cfg       sink    index, data (always ready)
//
// One item enters per cycle while the output is not stalled and the power table
// is not refilling. Stages: six index-bit multiplier stages, position product,
// seven reduction stages, one CORDIC iteration per stage, four rotation stages.
// After reset and after each frequency_ratio write the power table is refilled
// by repeated squaring; in_item is not ready then.
// A stalled output freezes the whole pipeline; in_item ready drops with it.
module rotary_position_pair_rotator_unit import rppr_pkg::*; #(
  parameter int MAX_POSITIONS  = DEF_MAX_POSITIONS,
  parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
  parameter int CORDIC_STAGES  = DEF_CORDIC_STAGES
) (
  input logic      clk,
  input logic      rst,
  rppr_in_if.sink  in_item,
  rppr_out_if.source out_item,
  rppr_cfg_if.sink cfg
);

  cfg_state_t cfg_st;
  logic       adv;
  logic       take;
  logic       bad_pos;
  logic       bad_idx;
  side_t      entry_side;

  logic               fq_vld;
  logic [ANGLE_W-1:0] fq_angle;
  side_t              fq_side;
  logic               rd_vld;
  logic signed [CW-1:0] rd_z;
  logic               rd_neg;
  side_t              rd_side;
  logic               cd_vld;
  logic signed [CW-1:0] cd_cos;
  logic signed [CW-1:0] cd_sin;
  logic               cd_neg;
  side_t              cd_side;

  assign cfg.ready = 1'b1;

  rppr_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .state    (cfg_st)
  );

  // advance when the output register is free or being taken
  assign adv           = !out_item.valid || out_item.ready;
  assign in_item.ready = adv && !cfg_st.busy;
  assign take          = in_item.valid && in_item.ready;

  // range checks at entry
  assign bad_pos = (AP_W'(in_item.position) >= cfg_st.active_positions) ||
                   (32'(in_item.position) >= 32'(MAX_POSITIONS));
  assign bad_idx = (HW_W'(in_item.pair_index) >= cfg_st.half_width) ||
                   (32'(in_item.pair_index) >= 32'(MAX_HALF_WIDTH));

  always_comb begin
    entry_side.opcode = in_item.opcode;
    entry_side.a      = in_item.first_value;
    entry_side.b      = in_item.second_value;
    if (bad_pos) entry_side.status = ST_BAD_POS;
    else if (bad_idx) entry_side.status = ST_BAD_IDX;
    else entry_side.status = ST_OK;
  end

  rppr_freq u_freq (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (take),
    .position   (in_item.position),
    .pair_index (in_item.pair_index),
    .in_side    (entry_side),
    .powers     (cfg_st.powers),
    .out_valid  (fq_vld),
    .angle      (fq_angle),
    .out_side   (fq_side)
  );

  rppr_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fq_vld),
    .angle     (fq_angle),
    .in_side   (fq_side),
    .out_valid (rd_vld),
    .z         (rd_z),
    .neg       (rd_neg),
    .out_side  (rd_side)
  );

  rppr_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (rd_vld),
    .z_in      (rd_z),
    .neg_in    (rd_neg),
    .in_side   (rd_side),
    .out_valid (cd_vld),
    .cos_out   (cd_cos),
    .sin_out   (cd_sin),
    .neg_out   (cd_neg),
    .out_side  (cd_side)
  );

  rppr_rotate u_rotate (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (cd_vld),
    .cos_in        (cd_cos),
    .sin_in        (cd_sin),
    .neg           (cd_neg),
    .in_side       (cd_side),
    .out_valid     (out_item.valid),
    .first_result  (out_item.first_result),
    .second_result (out_item.second_result),
    .status        (out_item.status)
  );

  // no item may enter while the power table refills after a ratio write
  a_ratio_blocks_entry: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index == CFG_FREQUENCY_RATIO)
      |=> !(in_item.valid && in_item.ready))
    else $error("item accepted during power table refill");

  // status leaving the pipeline is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> (out_item.status == ST_OK || out_item.status == ST_BAD_POS ||
                        out_item.status == ST_BAD_IDX))
    else $error("undefined status code on output");

  // a stalled output stops entry in the same cycle
  a_stall_blocks_entry: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && !out_item.ready) |-> !in_item.ready)
    else $error("input ready while output stalled");

endmodule
